[hdl/utf8d_pkg.sv]
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants of the streaming UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContTag   = 8'h80;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Tag  = 8'hE0;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Tag  = 8'hC0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Tag  = 8'hF0;
  localparam logic [7:0] Pay2Mask  = 8'h1F;
  localparam logic [7:0] Pay3Mask  = 8'h0F;
  localparam logic [7:0] Pay4Mask  = 8'h07;
  localparam logic [7:0] ContPay   = 8'h3F;

  localparam logic [CpWidth-1:0] ReplCp = 21'h00FFFD;

  // Sequence lengths held in the expected-length register.
  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] Len2    = 3'd2;
  localparam logic [2:0] Len3    = 3'd3;
  localparam logic [2:0] Len4    = 3'd4;

  // Results caused by one byte: a run of replacement characters, then at most
  // one further code point.
  typedef struct packed {
    logic [2:0]         n_repl;
    logic               has_tail;
    logic [CpWidth-1:0] tail_cp;
    logic               tail_repl;
  } desc_t;

endpackage

[hdl/utf8d_parser.sv]
// ----------------------------------------------------------------------------
// utf8d_parser
// Sequence state of the decoder and the per-byte result descriptor.
// ----------------------------------------------------------------------------
module utf8d_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          byte_in_i,
  input  logic                text_end_i,
  output utf8d_pkg::desc_t    desc_o
);

  logic [utf8d_pkg::CpWidth-1:0] partial_q, partial_d;
  logic [2:0]                    expected_q, expected_d;
  logic [1:0]                    held_q, held_d;

  logic                          pending;
  logic                          is_cont;
  logic [1:0]                    held_inc;
  logic                          seq_done;
  logic [utf8d_pkg::CpWidth-1:0] partial_ext;

  assign pending     = (expected_q != utf8d_pkg::LenNone);
  assign is_cont     = ((byte_in_i & utf8d_pkg::ContMask) == utf8d_pkg::ContTag);
  assign held_inc    = held_q + 2'd1;
  // The held count wraps after the fourth byte, which also completes a sequence.
  assign seq_done    = ({1'b0, held_inc} >= expected_q) || (held_inc == 2'd0);
  assign partial_ext = {partial_q[utf8d_pkg::CpWidth-7:0],
                        byte_in_i[5:0] & utf8d_pkg::ContPay[5:0]};

  always_comb begin
    desc_o     = '0;
    partial_d  = partial_q;
    expected_d = expected_q;
    held_d     = held_q;

    if (pending && is_cont) begin
      if (seq_done) begin
        desc_o.has_tail  = 1'b1;
        desc_o.tail_cp   = partial_ext;
        desc_o.tail_repl = 1'b0;
        partial_d        = '0;
        expected_d       = utf8d_pkg::LenNone;
        held_d           = '0;
      end else begin
        partial_d = partial_ext;
        held_d    = held_inc;
      end
    end else begin
      // A broken sequence gives one replacement per held byte, then the
      // byte is parsed as a new lead.
      if (pending) begin
        desc_o.n_repl = {1'b0, held_q};
      end
      partial_d  = '0;
      expected_d = utf8d_pkg::LenNone;
      held_d     = '0;
      if (!byte_in_i[7]) begin
        desc_o.has_tail = 1'b1;
        desc_o.tail_cp  = {13'd0, byte_in_i};
      end else if ((byte_in_i & utf8d_pkg::Lead2Mask) == utf8d_pkg::Lead2Tag) begin
        partial_d  = {16'd0, byte_in_i[4:0] & utf8d_pkg::Pay2Mask[4:0]};
        expected_d = utf8d_pkg::Len2;
        held_d     = 2'd1;
      end else if ((byte_in_i & utf8d_pkg::Lead3Mask) == utf8d_pkg::Lead3Tag) begin
        partial_d  = {17'd0, byte_in_i[3:0] & utf8d_pkg::Pay3Mask[3:0]};
        expected_d = utf8d_pkg::Len3;
        held_d     = 2'd1;
      end else if ((byte_in_i & utf8d_pkg::Lead4Mask) == utf8d_pkg::Lead4Tag) begin
        partial_d  = {18'd0, byte_in_i[2:0] & utf8d_pkg::Pay4Mask[2:0]};
        expected_d = utf8d_pkg::Len4;
        held_d     = 2'd1;
      end else begin
        desc_o.has_tail  = 1'b1;
        desc_o.tail_cp   = utf8d_pkg::ReplCp;
        desc_o.tail_repl = 1'b1;
      end
    end

    // A sequence still open at the end of the text is flushed. No tail can
    // exist here, so the extra replacements simply extend the run.
    if (text_end_i && (expected_d != utf8d_pkg::LenNone)) begin
      desc_o.n_repl = desc_o.n_repl + {1'b0, held_d};
      partial_d     = '0;
      expected_d    = utf8d_pkg::LenNone;
      held_d        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q  <= '0;
      expected_q <= utf8d_pkg::LenNone;
      held_q     <= '0;
    end else if (take_i) begin
      partial_q  <= partial_d;
      expected_q <= expected_d;
      held_q     <= held_d;
    end
  end

endmodule

[hdl/utf8d_serializer.sv]
// ----------------------------------------------------------------------------
// utf8d_serializer
// Holds a byte's descriptor, giving its results one per cycle unless stalled.
// ----------------------------------------------------------------------------
module utf8d_serializer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  utf8d_pkg::desc_t              desc_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [utf8d_pkg::CpWidth-1:0] code_point_o,
  output logic                          replaced_o,
  output logic                          run_last_o
);

  logic                          valid_q, valid_d;
  logic [2:0]                    rem_q, rem_d;
  logic                          tail_q, tail_d;
  logic [utf8d_pkg::CpWidth-1:0] cp_q, cp_d;
  logic                          trepl_q, trepl_d;
  logic                          out_take;

  always_comb begin
    if (rem_q != 3'd0) begin
      code_point_o = utf8d_pkg::ReplCp;
      replaced_o   = 1'b1;
      run_last_o   = (rem_q == 3'd1) && !tail_q;
    end else begin
      code_point_o = cp_q;
      replaced_o   = trepl_q;
      run_last_o   = 1'b1;
    end
  end

  assign out_valid_o = valid_q;
  assign out_take    = valid_q && out_ready_i;
  // A new byte may enter while the last result of the previous one leaves.
  assign free_o      = !valid_q || (out_ready_i && run_last_o);

  always_comb begin
    valid_d = valid_q;
    rem_d   = rem_q;
    tail_d  = tail_q;
    cp_d    = cp_q;
    trepl_d = trepl_q;
    if (out_take) begin
      if (run_last_o) begin
        valid_d = 1'b0;
      end else if (rem_q != 3'd0) begin
        rem_d = rem_q - 3'd1;
      end
    end
    if (load_i) begin
      valid_d = 1'b1;
      rem_d   = desc_i.n_repl;
      tail_d  = desc_i.has_tail;
      cp_d    = desc_i.tail_cp;
      trepl_d = desc_i.tail_repl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rem_q   <= '0;
      tail_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      rem_q   <= rem_d;
      tail_q  <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q    <= cp_d;
    trepl_q <= trepl_d;
  end

endmodule

[hdl/utf8_stream_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Lenient streaming UTF-8 decoder: bytes in, code points out.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i/in_ready_o) carries one byte and an
// end-of-text flag per item. The output channel (out_valid_o/out_ready_i)
// carries one code point per item, with replaced_o marking U+FFFD that stands
// for malformed input and run_last_o marking the last result of an input byte.
// A byte gives zero to four results, the first in the cycle after it is
// accepted; the rest follow one per cycle while the receiver takes them.
// Throughput is one byte per cycle while each byte gives at most one result
// and the receiver takes it; a byte with more results holds the input until
// its last is taken, as the output register hands out one result per cycle.
// Bytes that only extend a pending sequence give no result but can stall.
// Reset clears the pending sequence and empties the output register.
// While the receiver stalls, the current result holds and the input is
// accepted only once the last result of the previous byte is taken.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    byte_in_i,
  input  logic                          text_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [utf8d_pkg::CpWidth-1:0] code_point_o,
  output logic                          replaced_o,
  output logic                          run_last_o
);

  utf8d_pkg::desc_t desc;
  logic             in_take;
  logic             load;
  logic             free;

  assign in_ready_o = free;
  assign in_take    = in_valid_i && free;
  assign load       = in_take && ((desc.n_repl != 3'd0) || desc.has_tail);

  utf8d_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (in_take),
    .byte_in_i  (byte_in_i),
    .text_end_i (text_end_i),
    .desc_o     (desc)
  );

  utf8d_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .desc_i       (desc),
    .free_o       (free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .code_point_o (code_point_o),
    .replaced_o   (replaced_o),
    .run_last_o   (run_last_o)
  );

endmodule

[hdl/utf8d_checker.sv]
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks of the UTF-8 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utf8d_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [utf8d_pkg::CpWidth-1:0] code_point_o,
  input logic                          replaced_o,
  input logic                          run_last_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its code point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(code_point_o))
    else $error("code point changed while stalled");

  // A replacement always carries U+FFFD.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && replaced_o |-> code_point_o == utf8d_pkg::ReplCp)
    else $error("replacement with wrong code point");

  // No new byte enters while results of the current byte remain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> !in_ready_o)
    else $error("input ready in the middle of a result run");

  // A run that is not finished continues in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !run_last_o |=> out_valid_o)
    else $error("result run ended early");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .code_point_o (code_point_o),
  .replaced_o   (replaced_o),
  .run_last_o   (run_last_o)
);

[test/utf8_cp_checker.sv]
// ----------------------------------------------------------------------------
// utf8_cp_checker
// Watches both channels of the UTF-8 decoder, works out the code points that
// each accepted byte should give, and compares them with the results taken.
// ----------------------------------------------------------------------------
module utf8_cp_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [7:0]                    byte_in_i,
  input  logic                          text_end_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [utf8d_pkg::CpWidth-1:0] code_point_i,
  input  logic                          replaced_i,
  input  logic                          run_last_i,
  output int                            mismatch_count_o,
  output int                            cps_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [utf8d_pkg::CpWidth-1:0] cp;
    logic                          repl;
    logic                          run_last;
  } cp_result_t;

  cp_result_t         cp_expect_q[$];
  cp_result_t         want_r;
  int                 mismatch_count = 0;
  int                 pending_n      = 0;

  // Decoder state as the predictor sees it.
  logic [utf8d_pkg::CpWidth-1:0] partial_cp = '0;
  logic [2:0]                    seq_len    = utf8d_pkg::LenNone;
  logic [1:0]                    held       = '0;

  assign mismatch_count_o = mismatch_count;
  assign cps_pending_o    = pending_n;

  function automatic void push_cp(logic [utf8d_pkg::CpWidth-1:0] cp, logic repl);
    cp_result_t r;
    r.cp       = cp;
    r.repl     = repl;
    r.run_last = 1'b0;
    cp_expect_q.insert(cp_expect_q.size(), r);
  endfunction

  function automatic void clear_seq();
    partial_cp = '0;
    seq_len    = utf8d_pkg::LenNone;
    held       = '0;
  endfunction

  // Every byte held by a broken sequence stands for one replacement character.
  function automatic void flush_seq();
    for (int k = 0; k < held; k++) push_cp(utf8d_pkg::ReplCp, 1'b1);
    clear_seq();
  endfunction

  function automatic void open_lead(logic [7:0] b);
    if (b < 8'h80) begin
      push_cp(utf8d_pkg::CpWidth'(b), 1'b0);
    end else if ((b & utf8d_pkg::Lead2Mask) == utf8d_pkg::Lead2Tag) begin
      partial_cp = utf8d_pkg::CpWidth'(b & utf8d_pkg::Pay2Mask);
      seq_len    = utf8d_pkg::Len2;
      held       = 2'd1;
    end else if ((b & utf8d_pkg::Lead3Mask) == utf8d_pkg::Lead3Tag) begin
      partial_cp = utf8d_pkg::CpWidth'(b & utf8d_pkg::Pay3Mask);
      seq_len    = utf8d_pkg::Len3;
      held       = 2'd1;
    end else if ((b & utf8d_pkg::Lead4Mask) == utf8d_pkg::Lead4Tag) begin
      partial_cp = utf8d_pkg::CpWidth'(b & utf8d_pkg::Pay4Mask);
      seq_len    = utf8d_pkg::Len4;
      held       = 2'd1;
    end else begin
      push_cp(utf8d_pkg::ReplCp, 1'b1);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic fin);
    int before_n;
    before_n = cp_expect_q.size();
    if (seq_len != utf8d_pkg::LenNone) begin
      if ((b & utf8d_pkg::ContMask) == utf8d_pkg::ContTag) begin
        partial_cp = {partial_cp[utf8d_pkg::CpWidth-7:0], b[5:0]};
        held       = held + 2'd1;
        // The held count is two bits wide, so a four-byte sequence completes
        // when it wraps round to zero.
        if ({1'b0, held} >= seq_len || held == 2'd0) begin
          push_cp(partial_cp, 1'b0);
          clear_seq();
        end
      end else begin
        flush_seq();
        open_lead(b);
      end
    end else begin
      open_lead(b);
    end
    if (fin && seq_len != utf8d_pkg::LenNone) flush_seq();
    if (cp_expect_q.size() > before_n) cp_expect_q[cp_expect_q.size()-1].run_last = 1'b1;
  endfunction

  function automatic void note_mismatch(string what);
    if (mismatch_count < 10) $display("[%0t] %s", $realtime, what);
    mismatch_count++;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // Results are taken before the byte of this edge is decoded: a byte
      // accepted now cannot have produced a result at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (cp_expect_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result cp=%h repl=%b last=%b",
                                  code_point_i, replaced_i, run_last_i));
        end else begin
          want_r = cp_expect_q.pop_front();
          if (code_point_i !== want_r.cp || replaced_i !== want_r.repl ||
              run_last_i !== want_r.run_last)
            note_mismatch($sformatf(
                "expected cp=%h repl=%b last=%b, got cp=%h repl=%b last=%b",
                want_r.cp, want_r.repl, want_r.run_last,
                code_point_i, replaced_i, run_last_i));
        end
      end
      if (in_valid_i && in_ready_i) decode_byte(byte_in_i, text_end_i);
      pending_n <= cp_expect_q.size();
    end
  end

endmodule

[test/tb_utf8_stream_decoder.sv]
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder
// Feeds the UTF-8 decoder with directed byte sequences and then with random
// text, mostly well-formed characters mixed with truncated sequences and
// stray bytes, under two patterns of sender and receiver stalls and one without.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 2000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [7:0]                    byte_in = '0;
  logic                          text_end = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [utf8d_pkg::CpWidth-1:0] code_point;
  logic                          replaced;
  logic                          run_last;

  int mismatches;
  int cps_pending;
  int bytes_sent = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  utf8_stream_decoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .byte_in_i   (byte_in),
    .text_end_i  (text_end),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .code_point_o(code_point),
    .replaced_o  (replaced),
    .run_last_o  (run_last)
  );

  utf8_cp_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .byte_in_i       (byte_in),
    .text_end_i      (text_end),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .code_point_i    (code_point),
    .replaced_i      (replaced),
    .run_last_i      (run_last),
    .mismatch_count_o(mismatches),
    .cps_pending_o   (cps_pending)
  );

  always @(posedge clk_i) begin
    if (rst_ni) out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
          $display("** utf8_stream_decoder: FAILED **");
          $finish;
        end
      end
    end
  end

  // Valid stays high from one item to the next unless the sender idles.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    text_end <= fin;
    do @(posedge clk_i); while (!in_ready);
    bytes_sent++;
  endtask

  // Holds the input back until every outstanding result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (cps_pending != 0);
  endtask

  task automatic send_seq(input logic [7:0] seq[$], input logic fin);
    foreach (seq[i]) send_byte(seq[i], fin && (i == seq.size() - 1));
  endtask

  function automatic logic [7:0] lead_byte(int len);
    case (len)
      2:       return {3'b110, 5'($urandom)};
      3:       return {4'b1110, 4'($urandom)};
      default: return {5'b11110, 3'($urandom)};
    endcase
  endfunction

  function automatic logic random_end();
    return ($urandom_range(99) < 6);
  endfunction

  task automatic send_random_char();
    int pick;
    int len;
    int conts;
    pick = $urandom_range(99);
    if (pick < 25) begin
      send_byte(8'($urandom_range(127)), random_end());
    end else if (pick < 85) begin
      len = $urandom_range(2, 4);
      // Mostly complete characters; some stop short and get broken by the
      // byte that follows or flushed at the end of the text.
      conts = (pick < 70) ? len - 1 : $urandom_range(0, len - 2);
      send_byte(lead_byte(len), (conts == 0) && random_end());
      for (int k = 1; k <= conts; k++)
        send_byte({2'b10, 6'($urandom)}, (k == conts) && random_end());
    end else begin
      send_byte(8'($urandom_range(255)), random_end());
    end
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct, input int n_bytes);
    int target;
    drain_results();
    snd_idle_pct <= snd_pct;
    rcv_idle_pct <= rcv_pct;
    @(posedge clk_i);
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) send_random_char();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_seq('{8'h00, 8'h7F}, 1'b0);
    send_seq('{8'hC2, 8'hA9}, 1'b0);
    send_seq('{8'hEF, 8'hBF, 8'hBD}, 1'b0);          // a genuine U+FFFD
    send_seq('{8'hF7, 8'hBF, 8'hBF, 8'hBF}, 1'b0);   // largest code point
    send_seq('{8'h80, 8'hFF}, 1'b0);                 // stray bytes
    send_seq('{8'hE2, 8'h82, 8'h41}, 1'b0);          // broken by ASCII
    send_seq('{8'hF0, 8'h80, 8'h80, 8'hFF}, 1'b0);   // broken by a stray byte
    send_seq('{8'hF4, 8'h8F, 8'hBF}, 1'b1);          // text ends mid-sequence
    send_seq('{8'hC3}, 1'b1);

    run_phase(29, 84, 137);
    run_phase(84, 29, 137);
    run_phase(0, 0, 137);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && cps_pending == 0) begin
      $display("** utf8_stream_decoder: PASSED **");
    end else begin
      $display("** utf8_stream_decoder: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/utf8d_pkg.sv
hdl/utf8d_parser.sv
hdl/utf8d_serializer.sv
hdl/utf8_stream_decoder.sv
hdl/utf8d_checker.sv
test/utf8_cp_checker.sv
test/tb_utf8_stream_decoder.sv
